@@ rtl/paged_allocator_with_translation_unit_defines.svh @@
// Assertion macros shared by the paged allocator RTL.
`ifndef PAGED_ALLOCATOR_WITH_TRANSLATION_UNIT_DEFINES_SVH
`define PAGED_ALLOCATOR_WITH_TRANSLATION_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define PATU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define PATU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/patu_pkg.sv @@
// Shared types and codes of the paged allocator.
package patu_pkg;

    // Request field widths
    localparam int CMD_W  = 2;
    localparam int PID_W  = 4;
    localparam int SIZE_W = 21;
    localparam int ADDR_W = 20;
    localparam int DATA_W = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd3;

    // Frame-table scan operations
    localparam logic [1:0] SCAN_COUNT = 2'd0;
    localparam logic [1:0] SCAN_TAKE  = 2'd1;
    localparam logic [1:0] SCAN_FIND  = 2'd2;
    localparam logic [1:0] SCAN_CUT   = 2'd3;

    // Result kinds
    localparam logic [1:0] RES_FAIL  = 2'd0;
    localparam logic [1:0] RES_ALLOC = 2'd1;
    localparam logic [1:0] RES_OK    = 2'd2;
    localparam logic [1:0] RES_READ  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       clear;
        logic       capture;
        logic       scan_start;
        logic       scan_run;
        logic [1:0] scan_op;
        logic       brk_write;
        logic       walk_start;
        logic       walk_read;
        logic       walk_step;
        logic       ram_go;
        logic       load_out;
        logic [1:0] res_kind;
    } patu_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic found;
        logic alloc_ok;
        logic walk_end;
        logic walk_own;
        logic bad_pid;
        logic is_alloc;
        logic is_free;
        logic is_write;
    } patu_status_t;

endpackage

@@ rtl/paged_allocator_with_translation_unit.sv @@
// Paged frame allocator with per-process translation: one request at a time,
// each served by scanning the frame table one entry per cycle through its
// single read port. Allocate runs a count pass, then a take pass; read and
// write run a lookup pass, then one RAM access; free runs a lookup, a link cut
// pass and a chain walk. After reset the block sweeps the byte RAM and the
// owner and link tables to their reset values and holds in_stall high
// meanwhile. A finished result waits in an output register while the next
// request is accepted.
module paged_allocator_with_translation_unit
    import patu_pkg::*;
#(
    parameter int OFFSET_BITS = 10,
    parameter int ADDR_BITS   = 20,
    parameter int NUM_FRAMES  = 1024,
    parameter int MAX_PROCS   = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  command,
    input  logic [PID_W-1:0]  process_id,
    input  logic [SIZE_W-1:0] request_size,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              status,
    output logic [ADDR_W-1:0] alloc_address,
    output logic [DATA_W-1:0] read_data
);

    patu_cmd_t    cmd;
    patu_status_t st;

    // Sequencer
    patu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .st        (st)
    );

    // Tables, RAM and result registers
    patu_datapath #(
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .NUM_FRAMES  (NUM_FRAMES),
        .MAX_PROCS   (MAX_PROCS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .command       (command),
        .process_id    (process_id),
        .request_size  (request_size),
        .address       (address),
        .write_data    (write_data),
        .status        (status),
        .alloc_address (alloc_address),
        .read_data     (read_data)
    );

endmodule

@@ rtl/patu_datapath.sv @@
// Frame tables, byte RAM, scan pipeline and result registers of the allocator.
module patu_datapath
    import patu_pkg::*;
#(
    parameter int OFFSET_BITS = 10,
    parameter int ADDR_BITS   = 20,
    parameter int NUM_FRAMES  = 1024,
    parameter int MAX_PROCS   = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  patu_cmd_t           cmd,
    output patu_status_t        st,
    input  logic [CMD_W-1:0]    command,
    input  logic [PID_W-1:0]    process_id,
    input  logic [SIZE_W-1:0]   request_size,
    input  logic [ADDR_W-1:0]   address,
    input  logic [DATA_W-1:0]   write_data,
    output logic                status,
    output logic [ADDR_W-1:0]   alloc_address,
    output logic [DATA_W-1:0]   read_data
);

    localparam int FI  = $clog2(NUM_FRAMES);
    localparam int FB1 = $clog2(NUM_FRAMES + 1);
    localparam int RW  = FI + OFFSET_BITS;
    localparam int VPW = ADDR_BITS - OFFSET_BITS;
    localparam int BW  = ADDR_BITS + 1;
    localparam int PGW = SIZE_W + 1 - OFFSET_BITS;
    localparam int PIW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW  = 40;
    localparam longint RAM_DEPTH = longint'(NUM_FRAMES) << OFFSET_BITS;
    localparam logic [FB1-1:0] END_MARK = FB1'(NUM_FRAMES);
    localparam logic [RW:0]    CLR_LAST = (RW + 1)'(RAM_DEPTH);
    localparam logic [SIZE_W:0] PAGE_MASK = (SIZE_W + 1)'((64'd1 << OFFSET_BITS) - 64'd1);

    // Memories
    logic [PID_W-1:0]  owner_mem [NUM_FRAMES];
    logic [VPW-1:0]    vpage_mem [NUM_FRAMES];
    logic [FB1-1:0]    next_mem  [NUM_FRAMES];
    logic [DATA_W-1:0] ram_mem   [NUM_FRAMES << OFFSET_BITS];

    logic [PID_W-1:0]  owner_rd;
    logic [VPW-1:0]    vpage_rd;
    logic [FB1-1:0]    next_rd;
    logic [DATA_W-1:0] ram_rd;

    // Per-process break registers
    logic [BW-1:0] brk_reg [MAX_PROCS];

    // Captured request
    logic [CMD_W-1:0]  cmd_q_reg;
    logic [PID_W-1:0]  pid_q_reg;
    logic [PGW-1:0]    pages_q_reg;
    logic [VPW-1:0]    vpn_q_reg;
    logic [OFFSET_BITS-1:0] off_q_reg;
    logic [DATA_W-1:0] wdata_q_reg;
    logic              bad_q_reg;
    logic [BW-1:0]     brk_q_reg;

    // Scan and walk state
    logic [FB1-1:0] idx_reg, idx_next;
    logic           pipe_vld_reg, pipe_vld_next;
    logic [FI-1:0]  pipe_idx_reg;
    logic [FB1-1:0] freecnt_reg, freecnt_next;
    logic [FB1-1:0] k_reg, k_next;
    logic [FB1-1:0] prev_reg, prev_next;
    logic [VPW-1:0] vp_reg;
    logic           found_reg, found_next;
    logic [FB1-1:0] hit_reg;
    logic [FB1-1:0] walk_addr_reg, walk_addr_next;
    logic [FB1-1:0] steps_reg, steps_next;
    logic [RW:0]    clr_reg;

    logic [ADDR_BITS+ADDR_W-1:0] addr_wide;
    logic [SIZE_W:0]  size_sum;
    logic [8:0]       pid_minus;
    logic [PIW-1:0]   pid_idx;
    logic [CW-1:0]    grow;
    logic             scan_active;
    logic             rd_en;
    logic [FI-1:0]    rd_addr;
    logic             k_lt;
    logic             count_hit, take_hit, find_hit, cut_hit;
    logic             ram_re;
    logic [RW-1:0]    ram_addr;

    logic             owner_we, vpage_we, next_we, ram_we;
    logic [FI-1:0]    owner_wa, vpage_wa, next_wa;
    logic [PID_W-1:0] owner_wd;
    logic [VPW-1:0]   vpage_wd;
    logic [FB1-1:0]   next_wd;
    logic [RW-1:0]    ram_wa;
    logic [DATA_W-1:0] ram_wd;

    // Decode the request and the address split
    assign addr_wide = (ADDR_BITS + ADDR_W)'(address);
    assign size_sum  = (SIZE_W + 1)'(request_size) + PAGE_MASK;
    assign pid_minus = 9'(pid_q_reg) - 9'd1;
    assign pid_idx   = pid_minus[PIW-1:0];
    assign grow      = CW'(pages_q_reg) << OFFSET_BITS;

    // Hit conditions on the scan data
    assign scan_active = pipe_vld_reg && cmd.scan_run;
    assign k_lt      = CW'(k_reg) < CW'(pages_q_reg);
    assign count_hit = scan_active && (cmd.scan_op == SCAN_COUNT) && (owner_rd == '0);
    assign take_hit  = scan_active && (cmd.scan_op == SCAN_TAKE) && (owner_rd == '0) && k_lt;
    assign find_hit  = scan_active && (cmd.scan_op == SCAN_FIND) && !found_reg &&
                       (owner_rd == pid_q_reg) && (vpage_rd == vpn_q_reg);
    assign cut_hit   = scan_active && (cmd.scan_op == SCAN_CUT) && (next_rd == hit_reg);

    // Frame-table read port
    assign rd_en   = cmd.walk_read || (cmd.scan_run && (idx_reg < END_MARK));
    assign rd_addr = cmd.walk_read ? walk_addr_reg[FI-1:0] : idx_reg[FI-1:0];

    assign ram_re   = cmd.ram_go && (cmd_q_reg == CMD_READ);
    assign ram_addr = {hit_reg[FI-1:0], off_q_reg};

    // Status to the controller
    always_comb
    begin
        st.clear_done = (clr_reg == CLR_LAST);
        st.scan_done  = (idx_reg == END_MARK) && !pipe_vld_reg;
        st.found      = found_reg;
        st.alloc_ok   = (CW'(freecnt_reg) >= CW'(pages_q_reg)) &&
                        ((CW'(brk_q_reg) + grow) <= (CW'(1) << ADDR_BITS));
        st.walk_end   = (walk_addr_reg >= END_MARK) || (steps_reg >= END_MARK);
        st.walk_own   = (owner_rd == pid_q_reg);
        st.bad_pid    = bad_q_reg;
        st.is_alloc   = (cmd_q_reg == CMD_ALLOC);
        st.is_free    = (cmd_q_reg == CMD_FREE);
        st.is_write   = (cmd_q_reg == CMD_WRITE);
    end

    // Select the write of each memory
    always_comb
    begin
        owner_we = 1'b0;
        owner_wa = '0;
        owner_wd = '0;
        vpage_we = 1'b0;
        vpage_wa = pipe_idx_reg;
        vpage_wd = vp_reg;
        next_we  = 1'b0;
        next_wa  = '0;
        next_wd  = END_MARK;
        ram_we   = 1'b0;
        ram_wa   = ram_addr;
        ram_wd   = wdata_q_reg;
        priority if (cmd.clear)
        begin
            owner_we = 1'b1;
            owner_wa = clr_reg[RW-1:OFFSET_BITS];
            next_we  = 1'b1;
            next_wa  = clr_reg[RW-1:OFFSET_BITS];
            ram_we   = 1'b1;
            ram_wa   = clr_reg[RW-1:0];
            ram_wd   = '0;
        end
        else if (take_hit)
        begin
            owner_we = 1'b1;
            owner_wa = pipe_idx_reg;
            owner_wd = pid_q_reg;
            vpage_we = 1'b1;
            next_we  = (prev_reg != END_MARK);
            next_wa  = prev_reg[FI-1:0];
            next_wd  = FB1'(pipe_idx_reg);
        end
        else if (cut_hit)
        begin
            next_we = 1'b1;
            next_wa = pipe_idx_reg;
        end
        else if (cmd.walk_step)
        begin
            owner_we = 1'b1;
            owner_wa = walk_addr_reg[FI-1:0];
            next_we  = 1'b1;
            next_wa  = walk_addr_reg[FI-1:0];
        end
        else if (cmd.ram_go && (cmd_q_reg == CMD_WRITE))
        begin
            ram_we = 1'b1;
        end
    end

    // Frame tables
    always_ff @(posedge clk)
    begin
        if (owner_we)
            owner_mem[owner_wa] <= owner_wd;
        if (vpage_we)
            vpage_mem[vpage_wa] <= vpage_wd;
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (rd_en)
        begin
            owner_rd <= owner_mem[rd_addr];
            vpage_rd <= vpage_mem[rd_addr];
            next_rd  <= next_mem[rd_addr];
        end
    end

    // Byte RAM
    always_ff @(posedge clk)
    begin
        if (ram_we)
            ram_mem[ram_wa] <= ram_wd;
        if (ram_re)
            ram_rd <= ram_mem[ram_addr];
    end

    // Next values of scan and walk state
    always_comb
    begin
        idx_next       = idx_reg;
        pipe_vld_next  = 1'b0;
        freecnt_next   = freecnt_reg;
        k_next         = k_reg;
        prev_next      = prev_reg;
        found_next     = found_reg;
        walk_addr_next = walk_addr_reg;
        steps_next     = steps_reg;
        if (cmd.scan_start)
        begin
            idx_next     = '0;
            freecnt_next = '0;
            k_next       = '0;
            prev_next    = END_MARK;
            found_next   = 1'b0;
        end
        else
        begin
            if (cmd.scan_run && (idx_reg < END_MARK))
            begin
                idx_next      = idx_reg + 1'b1;
                pipe_vld_next = 1'b1;
            end
            if (count_hit)
                freecnt_next = freecnt_reg + 1'b1;
            if (take_hit)
            begin
                k_next    = k_reg + 1'b1;
                prev_next = FB1'(pipe_idx_reg);
            end
            if (find_hit)
                found_next = 1'b1;
        end
        if (cmd.walk_start)
        begin
            walk_addr_next = hit_reg;
            steps_next     = '0;
        end
        else if (cmd.walk_step)
        begin
            walk_addr_next = next_rd;
            steps_next     = steps_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= END_MARK;
            pipe_vld_reg  <= 1'b0;
            freecnt_reg   <= '0;
            k_reg         <= '0;
            prev_reg      <= END_MARK;
            found_reg     <= 1'b0;
            walk_addr_reg <= END_MARK;
            steps_reg     <= '0;
            clr_reg       <= '0;
            for (int i = 0; i < MAX_PROCS; i++)
                brk_reg[i] <= '0;
        end
        else
        begin
            idx_reg       <= idx_next;
            pipe_vld_reg  <= pipe_vld_next;
            freecnt_reg   <= freecnt_next;
            k_reg         <= k_next;
            prev_reg      <= prev_next;
            found_reg     <= found_next;
            walk_addr_reg <= walk_addr_next;
            steps_reg     <= steps_next;
            if (cmd.clear && (clr_reg != CLR_LAST))
                clr_reg <= clr_reg + 1'b1;
            if (cmd.brk_write)
                brk_reg[pid_idx] <= BW'(CW'(brk_q_reg) + grow);
        end
    end

    // Payload registers: request, scan data and results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_q_reg   <= command;
            pid_q_reg   <= process_id;
            pages_q_reg <= size_sum[SIZE_W:OFFSET_BITS];
            vpn_q_reg   <= addr_wide[ADDR_BITS-1:OFFSET_BITS];
            off_q_reg   <= address[OFFSET_BITS-1:0];
            wdata_q_reg <= write_data;
            bad_q_reg   <= (process_id == '0) || (9'(process_id) > 9'(MAX_PROCS));
        end
        if (cmd.scan_start && (cmd.scan_op == SCAN_COUNT))
            brk_q_reg <= bad_q_reg ? '0 : brk_reg[pid_idx];
        if (cmd.scan_start && (cmd.scan_op == SCAN_TAKE))
            vp_reg <= brk_q_reg[ADDR_BITS-1:OFFSET_BITS];
        else if (take_hit)
            vp_reg <= vp_reg + 1'b1;
        if (pipe_vld_next)
            pipe_idx_reg <= idx_reg[FI-1:0];
        if (find_hit)
            hit_reg <= FB1'(pipe_idx_reg);
        if (cmd.load_out)
        begin
            status        <= (cmd.res_kind == RES_FAIL);
            alloc_address <= (cmd.res_kind == RES_ALLOC) ? ADDR_W'(brk_q_reg) : '0;
            read_data     <= (cmd.res_kind == RES_READ) ? ram_rd : '0;
        end
    end

endmodule

@@ rtl/patu_ctrl.sv @@
// Sequencing state machine of the paged allocator.
module patu_ctrl
    import patu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    output patu_cmd_t    cmd,
    input  patu_status_t st
);

    `include "paged_allocator_with_translation_unit_defines.svh"

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DISPATCH = 4'd2;
    localparam logic [3:0] ST_COUNT    = 4'd3;
    localparam logic [3:0] ST_CHECK    = 4'd4;
    localparam logic [3:0] ST_TAKE     = 4'd5;
    localparam logic [3:0] ST_FIND     = 4'd6;
    localparam logic [3:0] ST_DECIDE   = 4'd7;
    localparam logic [3:0] ST_CUT      = 4'd8;
    localparam logic [3:0] ST_WALK_RD  = 4'd9;
    localparam logic [3:0] ST_WALK     = 4'd10;
    localparam logic [3:0] ST_RAM      = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] res_kind_reg, res_kind_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Step the sequencer and drive datapath commands
    always_comb
    begin
        state_next    = state_reg;
        res_kind_next = res_kind_reg;
        cmd           = '0;
        cmd.res_kind  = res_kind_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_op    = SCAN_COUNT;
                if (st.bad_pid)
                begin
                    res_kind_next = RES_FAIL;
                    state_next    = ST_DONE;
                end
                else if (st.is_alloc)
                    state_next = ST_COUNT;
                else
                    state_next = ST_FIND;
            end
            ST_COUNT:
            begin
                cmd.scan_run = 1'b1;
                cmd.scan_op  = SCAN_COUNT;
                if (st.scan_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (st.alloc_ok)
                begin
                    cmd.brk_write  = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_op    = SCAN_TAKE;
                    state_next     = ST_TAKE;
                end
                else
                begin
                    res_kind_next = RES_FAIL;
                    state_next    = ST_DONE;
                end
            end
            ST_TAKE:
            begin
                cmd.scan_run = 1'b1;
                cmd.scan_op  = SCAN_TAKE;
                if (st.scan_done)
                begin
                    res_kind_next = RES_ALLOC;
                    state_next    = ST_DONE;
                end
            end
            ST_FIND:
            begin
                cmd.scan_run = 1'b1;
                cmd.scan_op  = SCAN_FIND;
                if (st.found || st.scan_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!st.found)
                begin
                    res_kind_next = RES_FAIL;
                    state_next    = ST_DONE;
                end
                else if (st.is_free)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_op    = SCAN_CUT;
                    state_next     = ST_CUT;
                end
                else
                    state_next = ST_RAM;
            end
            ST_CUT:
            begin
                cmd.scan_run = 1'b1;
                cmd.scan_op  = SCAN_CUT;
                if (st.scan_done)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                if (st.walk_end)
                begin
                    res_kind_next = RES_OK;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.walk_read = 1'b1;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (st.walk_own)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = ST_WALK_RD;
                end
                else
                begin
                    res_kind_next = RES_OK;
                    state_next    = ST_DONE;
                end
            end
            ST_RAM:
            begin
                cmd.ram_go    = 1'b1;
                res_kind_next = st.is_write ? RES_OK : RES_READ;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken, then load the next one
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            res_kind_reg  <= RES_FAIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_kind_reg  <= res_kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PATU_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, state_reg == ST_DISPATCH,
        "accepted request not dispatched")
    `PATU_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state_reg) == ST_DONE,
        "result raised outside the done state")
    `PATU_ASSERT_NEXT(a_clear_once, state_reg != ST_CLEAR, state_reg != ST_CLEAR,
        "memory sweep restarted without reset")
    `PATU_ASSERT_NEXT(a_count_to_check, state_reg == ST_COUNT && st.scan_done,
        state_reg == ST_CHECK, "free count not followed by the allocation check")

endmodule
